FILE: design/zvc_pkg.sv
package zvc_pkg;

  localparam int unsigned AtanLen = 24;

  // Angle accumulator counts 1/256 of a hundredth of a degree.
  localparam logic signed [24:0] ZHalf = 25'sd4608000;
  localparam logic signed [24:0] ZFull = 25'sd9216000;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;
  localparam logic [15:0] Deg180 = 16'd18000;
  localparam logic [15:0] Deg360 = 16'd36000;
  localparam logic [14:0] Deg180Mul = 15'd18000;

  typedef struct packed {
    logic               nz;
    logic [15:0]        heading;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [24:0] z;
  } cordic_t;

  typedef struct packed {
    logic [14:0] radius;
    logic [15:0] ent_angle;
    logic [14:0] ent_tol;
    logic [11:0] half_diag;
  } zone_cfg_t;

  function automatic logic [20:0] atan_f(input int unsigned i);
    logic [20:0] r;
    case (i)
      0: r = 21'd1152000;
      1: r = 21'd680065;
      2: r = 21'd359328;
      3: r = 21'd182400;
      4: r = 21'd91554;
      5: r = 21'd45822;
      6: r = 21'd22916;
      7: r = 21'd11459;
      8: r = 21'd5730;
      9: r = 21'd2865;
      10: r = 21'd1432;
      11: r = 21'd716;
      12: r = 21'd358;
      13: r = 21'd179;
      14: r = 21'd90;
      15: r = 21'd45;
      16: r = 21'd22;
      17: r = 21'd11;
      18: r = 21'd6;
      19: r = 21'd3;
      20: r = 21'd1;
      21: r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  // Absolute angular difference folded into 0 to 180 degrees.
  function automatic logic [14:0] wrap_diff(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? (a - b) : (b - a);
    if (d > Deg180) begin
      d = Deg360 - d;
    end
    return d[14:0];
  endfunction

endpackage

FILE: design/zone_visit_check.sv
// Channel   Ports                                        Direction  Timing
// pose      start, busy, gyro_angle_i, pos_x_i, pos_y_i  in         taken when start & !busy
// result    done_o, visiting_o                           out        valid one cycle on done_o
// config    cfg_we_i, cfg_idx_i, cfg_data_i              in         written when cfg_we_i
//
// A pose word is taken in every cycle in which start is high; busy is never raised. Each
// word passes through one input register, one stage per CORDIC rotation (CORDIC_STEPS,
// capped at AtanLen) and five stages of folding, scaling and comparison.
// Reset clears only the valid bits and the configuration registers, but sets ent_tol to 18000.
// The receiver cannot stall, so the pipeline never holds.
module zone_visit_check #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] gyro_angle_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  output logic        done_o,
  output logic        visiting_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import zvc_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
  localparam logic [2:0] RegCx   = 3'd0;
  localparam logic [2:0] RegCy   = 3'd1;
  localparam logic [2:0] RegRad  = 3'd2;
  localparam logic [2:0] RegEnt  = 3'd3;
  localparam logic [2:0] RegTol  = 3'd4;
  localparam logic [2:0] RegHalf = 3'd5;

  logic signed [15:0] cx_q, cy_q;
  zone_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cfg_q <= '{radius: 15'd0, ent_angle: 16'd0, ent_tol: 15'd18000, half_diag: 12'd0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCx:   cx_q <= cfg_data_i;
        RegCy:   cy_q <= cfg_data_i;
        RegRad:  cfg_q.radius <= cfg_data_i[14:0];
        RegEnt:  cfg_q.ent_angle <= (cfg_data_i >= Deg360) ? (cfg_data_i - Deg360)
                                                             : cfg_data_i;
        RegTol:  cfg_q.ent_tol <= cfg_data_i[14:0];
        RegHalf: cfg_q.half_diag <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input stage: vector to the centre, heading, and the half-turn pre-rotation.
  logic signed [16:0] dx, dy;
  logic signed [31:0] xs, ys;
  logic [16:0] ht;
  cordic_t in_d;

  always_comb begin
    dx = {cx_q[15], cx_q} - {pos_x_i[15], pos_x_i};
    dy = {cy_q[15], cy_q} - {pos_y_i[15], pos_y_i};
    xs = signed'({{3{dx[16]}}, dx, 12'b0});
    ys = signed'({{3{dy[16]}}, dy, 12'b0});
    ht = 17'd81000 - {1'b0, gyro_angle_i};
    if (ht >= 17'd72000) begin
      ht = ht - 17'd72000;
    end else if (ht >= 17'd36000) begin
      ht = ht - 17'd36000;
    end
    in_d.nz      = (dx != 17'sd0) || (dy != 17'sd0);
    in_d.heading = ht[15:0];
    if (xs[31]) begin
      in_d.x = -xs;
      in_d.y = -ys;
      in_d.z = ZHalf;
    end else begin
      in_d.x = xs;
      in_d.y = ys;
      in_d.z = 25'sd0;
    end
  end

  logic    vld_s [Steps+1];
  cordic_t dat_s [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s[0] <= 1'b0;
    end else begin
      vld_s[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_s[0] <= in_d;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_rot
    zvc_cordic_stage #(
      .Idx(i)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (vld_s[i]),
      .data_i(dat_s[i]),
      .vld_o (vld_s[i+1]),
      .data_o(dat_s[i+1])
    );
  end

  zvc_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (vld_s[Steps]),
    .data_i    (dat_s[Steps]),
    .cfg_i     (cfg_q),
    .done_o    (done_o),
    .visiting_o(visiting_o)
  );

endmodule

FILE: design/zvc_cordic_stage.sv
module zvc_cordic_stage #(
  parameter int unsigned Idx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  zvc_pkg::cordic_t data_i,
  output logic             vld_o,
  output zvc_pkg::cordic_t data_o
);
  import zvc_pkg::*;

  logic    vld_q;
  cordic_t data_d, data_q;
  logic signed [24:0] atan_s;

  assign atan_s = signed'({4'b0, atan_f(Idx)});

  always_comb begin
    data_d = data_i;
    if (!data_i.y[31]) begin
      data_d.x = data_i.x + (data_i.y >>> Idx);
      data_d.y = data_i.y - (data_i.x >>> Idx);
      data_d.z = data_i.z + atan_s;
    end else begin
      data_d.x = data_i.x - (data_i.y >>> Idx);
      data_d.y = data_i.y + (data_i.x >>> Idx);
      data_d.z = data_i.z - atan_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

FILE: design/zvc_decide.sv
module zvc_decide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  zvc_pkg::cordic_t   data_i,
  input  zvc_pkg::zone_cfg_t cfg_i,
  output logic               done_o,
  output logic               visiting_o
);
  import zvc_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, done_q;
  logic nz1_q;
  logic [15:0] hd1_q, hd2_q;
  logic signed [24:0] zw_d, zw1_q;
  logic [29:0] xcl;
  logic [59:0] prod1_q;
  logic [24:0] zr;
  logic [16:0] br;
  logic [15:0] bear_d, bear2_q;
  logic [29:0] dist2_q, dist3_q;
  logic [14:0] dh3_q;
  logic t2_3_q, t3_3_q, t23_4_q, vis_q;
  logic [41:0] rhs3_q, rhs4_q;
  logic [44:0] p4_q;
  logic [29:0] lim_mul;

  // First stage: fold the angle and scale the CORDIC magnitude by the inverse gain.
  always_comb begin
    if (data_i.z[24]) begin
      zw_d = data_i.z + ZFull;
    end else if (data_i.z >= ZFull) begin
      zw_d = data_i.z - ZFull;
    end else begin
      zw_d = data_i.z;
    end
    xcl = data_i.x[31] ? 30'd0 : data_i.x[29:0];
  end

  // Second stage: round the bearing to hundredths of a degree.
  always_comb begin
    zr = unsigned'(zw1_q) + 25'd128;
    br = zr[24:8];
    if (br >= {1'b0, Deg360}) begin
      br = br - {1'b0, Deg360};
    end
    bear_d = nz1_q ? br[15:0] : 16'd0;
  end

  assign lim_mul = cfg_i.radius * Deg180Mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= vld_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nz1_q   <= data_i.nz;
    hd1_q   <= data_i.heading;
    zw1_q   <= zw_d;
    prod1_q <= xcl * InvGainQ30;

    hd2_q   <= hd1_q;
    bear2_q <= bear_d;
    dist2_q <= nz1_q ? prod1_q[59:30] : 30'd0;

    dh3_q   <= wrap_diff(bear2_q, hd2_q);
    t2_3_q  <= wrap_diff(bear2_q, cfg_i.ent_angle) <= cfg_i.ent_tol;
    t3_3_q  <= dist2_q < {2'b0, ({1'b0, cfg_i.radius} + {4'b0, cfg_i.half_diag}), 12'b0};
    dist3_q <= dist2_q;
    rhs3_q  <= {lim_mul, 12'b0};

    p4_q    <= dh3_q * dist3_q;
    rhs4_q  <= rhs3_q;
    t23_4_q <= t2_3_q && t3_3_q;

    vis_q   <= (p4_q <= {3'b0, rhs4_q}) && t23_4_q;
  end

  assign done_o     = done_q;
  assign visiting_o = vis_q;

endmodule
